FILE: rtl/spn_pkg.sv
// ----------------------------------------------------------------------------
// spn_pkg
// Types and codes shared by the shortest-process-next scheduler core and its
// divider.
// ----------------------------------------------------------------------------
package spn_pkg;

	localparam int DIV_DW = 56;
	localparam int DIV_VW = 32;

	localparam logic [1:0] CMD_INSERT   = 2'd0;
	localparam logic [1:0] CMD_SCHEDULE = 2'd1;
	localparam logic [1:0] CMD_DRAIN    = 2'd2;
	localparam logic [1:0] CMD_IGNORED  = 2'd3;

	localparam logic [1:0] KIND_DONE    = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;
	localparam logic [1:0] KIND_REJECT  = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] job_id;
		logic [7:0]  job_priority;
		logic [15:0] burst_time;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] done_id;
		logic [7:0]  done_priority;
		logic [15:0] done_burst;
		logic [31:0] turnaround;
		logic [23:0] normalized_turnaround;
		logic [39:0] mean_turnaround;
		logic [23:0] mean_normalized;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
		logic [15:0] burst;
		logic [31:0] arrival;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_POP_RD,
		ST_POP_CAP,
		ST_POP_TA,
		ST_POP_DIV,
		ST_SUM_T,
		ST_SUM_TW,
		ST_SUM_NW
	} state_t;

endpackage

FILE: rtl/spn_div.sv
// ----------------------------------------------------------------------------
// spn_div
// Restoring divider, one quotient bit per cycle. A divisor of zero yields an
// all-ones quotient.
// ----------------------------------------------------------------------------
module spn_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [spn_pkg::DIV_DW-1:0] dividend,
	input  logic [spn_pkg::DIV_VW-1:0] divisor,
	output logic                      done,
	output logic [spn_pkg::DIV_DW-1:0] quotient
);
	import spn_pkg::*;

	localparam int CW = $clog2(DIV_DW + 1);

	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [DIV_VW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(DIV_DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_DW-2:0], fits};
			rem_q <= fits ? DIV_VW'(trial - {1'b0, dvs_q}) : trial[DIV_VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/shortest_process_next_scheduler_core.sv
// ----------------------------------------------------------------------------
// shortest_process_next_scheduler_core
// Non-preemptive shortest-process-next job queue with turnaround statistics.
// ----------------------------------------------------------------------------
// One command at a time: busy is high from the cycle after start is taken
// until the command is finished. Waiting jobs sit in a single-port-read RAM
// used as a ring, sorted by burst. An insert walks from the tail towards the
// head, moving each waiting job with a longer burst up a slot through the RAM,
// and writes the new job where the search ends: behind the first job it meets
// with a shorter or equal burst, or at the head. A schedule pops the head job
// and runs the bit-serial 56-step divider to compute its normalized turnaround;
// a drain pops every waiting job in the same way, then runs the two divisions
// of the summary, or skips them when no job has completed yet. Rejected inserts
// and schedules on an empty queue do not raise busy. Results appear one cycle
// at a time on res_item with res_valid and cannot be held off; the last
// result of a command has last set.
// ----------------------------------------------------------------------------
module shortest_process_next_scheduler_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spn_pkg::cmd_t cmd_item,
	output logic          res_valid,
	output spn_pkg::res_t res_item
);
	import spn_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [47:0] MAX48 = '1;

	slot_t mem [QUEUE_DEPTH];
	slot_t rdata_s1;

	state_t state_q, state_d;
	logic [OW-1:0] occ_q;
	logic [OW-1:0] i_q;
	logic [AW-1:0] head_q;
	logic [31:0]   cur_q;
	logic [31:0]   cnt_q;
	logic [47:0]   tsum_q;
	logic [47:0]   nsum_q;
	logic          drain_q;
	cmd_t          cmd_q;
	slot_t         job_q;
	logic [31:0]   ta_q;
	logic [39:0]   mt_q;
	logic          res_valid_q;
	res_t          res_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	slot_t         wdata;
	logic          emit;
	res_t          res_d;
	logic          div_start, div_done;
	logic [DIV_DW-1:0] div_dividend, div_quo;
	logic [DIV_VW-1:0] div_divisor;
	logic [23:0]   norm;
	logic [32:0]   tsum_t;
	logic [31:0]   ta_now;
	slot_t         new_slot;

	function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, h} + {1'b0, off};
		if (s >= (AW+1)'(QUEUE_DEPTH)) begin
			s = s - (AW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? MAX48 : s[47:0];
	endfunction

	spn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign norm     = (|div_quo[DIV_DW-1:24]) ? 24'hFFFFFF : div_quo[23:0];
	assign tsum_t   = {1'b0, cur_q} + {17'b0, rdata_s1.burst};
	assign ta_now   = cur_q - job_q.arrival;
	assign new_slot = '{id: cmd_q.job_id, prio: cmd_q.job_priority,
		burst: cmd_q.burst_time, arrival: cur_q};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd_item.command)
						CMD_INSERT:   state_d = (occ_q == OW'(QUEUE_DEPTH)) ? ST_IDLE : ST_INS_RD;
						CMD_SCHEDULE: state_d = (occ_q == '0) ? ST_IDLE : ST_POP_RD;
						CMD_DRAIN:    state_d = (occ_q == '0) ? ST_SUM_T : ST_POP_RD;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_INS_RD:  state_d = (i_q == '0) ? ST_IDLE : ST_INS_CMP;
			ST_INS_CMP: state_d = (rdata_s1.burst > cmd_q.burst_time) ? ST_INS_RD : ST_IDLE;
			ST_POP_RD:  state_d = ST_POP_CAP;
			ST_POP_CAP: state_d = ST_POP_TA;
			ST_POP_TA:  state_d = ST_POP_DIV;
			ST_POP_DIV: begin
				if (div_done) begin
					priority if (!drain_q) state_d = ST_IDLE;
					else if (occ_q != '0) state_d = ST_POP_RD;
					else                  state_d = ST_SUM_T;
				end
			end
			ST_SUM_T:  state_d = (cnt_q == '0) ? ST_IDLE : ST_SUM_TW;
			ST_SUM_TW: state_d = div_done ? ST_SUM_NW : ST_SUM_TW;
			ST_SUM_NW: state_d = div_done ? ST_IDLE : ST_SUM_NW;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we           = 1'b0;
		re           = 1'b0;
		waddr        = head_q;
		raddr        = head_q;
		wdata        = new_slot;
		emit         = 1'b0;
		res_d        = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && cmd_item.command == CMD_INSERT && occ_q == OW'(QUEUE_DEPTH)) begin
					emit       = 1'b1;
					res_d.kind = KIND_REJECT;
					res_d.last = 1'b1;
				end
				if (start && cmd_item.command == CMD_SCHEDULE && occ_q == '0) begin
					emit       = 1'b1;
					res_d.kind = KIND_EMPTY;
					res_d.last = 1'b1;
				end
			end
			ST_INS_RD: begin
				if (i_q == '0) begin
					we = 1'b1;
				end else begin
					re    = 1'b1;
					raddr = ring(head_q, AW'(i_q - OW'(1)));
				end
			end
			ST_INS_CMP: begin
				we    = 1'b1;
				waddr = ring(head_q, i_q[AW-1:0]);
				if (rdata_s1.burst > cmd_q.burst_time) begin
					wdata = rdata_s1;
				end
			end
			ST_POP_RD: re = 1'b1;
			ST_POP_TA: begin
				div_start    = 1'b1;
				div_dividend = DIV_DW'({ta_now, 8'b0});
				div_divisor  = DIV_VW'(job_q.burst);
			end
			ST_POP_DIV: begin
				if (div_done) begin
					emit                        = 1'b1;
					res_d.kind                  = KIND_DONE;
					res_d.done_id               = job_q.id;
					res_d.done_priority         = job_q.prio;
					res_d.done_burst            = job_q.burst;
					res_d.turnaround            = ta_q;
					res_d.normalized_turnaround = norm;
					res_d.last                  = !drain_q;
				end
			end
			ST_SUM_T: begin
				if (cnt_q == '0) begin
					emit       = 1'b1;
					res_d.kind = KIND_SUMMARY;
					res_d.last = 1'b1;
				end else begin
					div_start    = 1'b1;
					div_dividend = {tsum_q, 8'b0};
					div_divisor  = cnt_q;
				end
			end
			ST_SUM_TW: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DIV_DW'(nsum_q);
					div_divisor  = cnt_q;
				end
			end
			ST_SUM_NW: begin
				if (div_done) begin
					emit                  = 1'b1;
					res_d.kind            = KIND_SUMMARY;
					res_d.mean_turnaround = mt_q;
					res_d.mean_normalized = norm;
					res_d.last            = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			head_q      <= '0;
			cur_q       <= '0;
			cnt_q       <= '0;
			tsum_q      <= '0;
			nsum_q      <= '0;
			drain_q     <= 1'b0;
			i_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit;
			unique case (state_q)
				ST_IDLE: begin
					i_q     <= occ_q;
					drain_q <= (cmd_item.command == CMD_DRAIN);
				end
				ST_INS_RD: begin
					if (i_q == '0) begin
						occ_q <= occ_q + OW'(1);
					end
				end
				ST_INS_CMP: begin
					if (rdata_s1.burst > cmd_q.burst_time) begin
						i_q <= i_q - OW'(1);
					end else begin
						occ_q <= occ_q + OW'(1);
					end
				end
				ST_POP_CAP: begin
					head_q <= ring(head_q, AW'(1));
					occ_q  <= occ_q - OW'(1);
					cur_q  <= tsum_t[32] ? 32'hFFFF_FFFF : tsum_t[31:0];
				end
				ST_POP_DIV: begin
					if (div_done) begin
						if (cnt_q != 32'hFFFF_FFFF) begin
							cnt_q <= cnt_q + 32'd1;
						end
						tsum_q <= sat_add48(tsum_q, {16'b0, ta_q});
						nsum_q <= sat_add48(nsum_q, {24'b0, norm});
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd_item;
		end
		if (state_q == ST_POP_CAP) begin
			job_q <= rdata_s1;
		end
		if (state_q == ST_POP_TA) begin
			ta_q <= ta_now;
		end
		if (state_q == ST_SUM_TW && div_done) begin
			mt_q <= (|div_quo[DIV_DW-1:40]) ? 40'hFF_FFFF_FFFF : div_quo[39:0];
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(QUEUE_DEPTH))
		else $error("queue occupancy beyond depth");

	a_item_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.last |=> !res_valid)
		else $error("result right after a non-final result");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd_item.command == CMD_INSERT && occ_q == OW'(QUEUE_DEPTH)
		|=> res_valid && res_item.kind == KIND_REJECT)
		else $error("full insert not rejected");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.kind == KIND_DONE |-> $past(state_q == ST_POP_DIV))
		else $error("job result outside pop");

endmodule
